[design/env_block_crc_validator_defines.svh]
// Assertion macros shared by the checker of the environment block CRC validator.
// Depends on nothing; included by the checker file.
`ifndef ENV_BLOCK_CRC_VALIDATOR_DEFINES_SVH
`define ENV_BLOCK_CRC_VALIDATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ECV_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ECV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/ecv_pkg.sv]
// Shared types, constants and match helpers for the environment block CRC validator.
// No dependencies; imported by the top level and the checker.
package ecv_pkg;

  localparam int POSITION_BITS  = 25;
  localparam int MAX_HINT_BYTES = 8;
  localparam int WIN_DEPTH      = 9;
  localparam int FILL_BITS      = $clog2(WIN_DEPTH + 1);
  localparam int HLEN_BITS      = 4;
  localparam int SIZE_BITS      = 25;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

  localparam logic [SIZE_BITS-1:0] SIZE_MIN   = SIZE_BITS'(5);
  localparam logic [SIZE_BITS-1:0] SIZE_RESET = SIZE_BITS'(65536);

  // Verdict codes
  localparam logic [1:0] VERDICT_NONE = 2'd0;
  localparam logic [1:0] VERDICT_LE   = 2'd1;
  localparam logic [1:0] VERDICT_BE   = 2'd2;

  // Config register indexes
  localparam logic [1:0] REG_BLOCK_SIZE  = 2'd0;
  localparam logic [1:0] REG_HINT_TEXT   = 2'd1;
  localparam logic [1:0] REG_HINT_LENGTH = 2'd2;

  // Built-in names. A literal sits right-aligned, so byte j holds the
  // character that lies j places behind the newest byte of the window.
  localparam logic [71:0] NAME_BOOTCMD  = 72'("bootcmd=");
  localparam logic [71:0] NAME_BOOTARGS = 72'("bootargs=");
  localparam logic [71:0] NAME_BAUDRATE = 72'("baudrate=");
  localparam logic [71:0] NAME_ETHADDR  = 72'("ethaddr=");
  localparam logic [71:0] NAME_STDIN    = 72'("stdin=");

  typedef logic [WIN_DEPTH-1:0][7:0] win_t;

  // One byte through the reflected CRC-32, eight bit steps.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? (CRC_POLY ^ {1'b0, c[31:1]}) : {1'b0, c[31:1]};
    end
    return c;
  endfunction

  // Fixed pattern ending at the newest window byte.
  function automatic logic name_ends(input win_t w, input logic [FILL_BITS-1:0] fill,
                                     input logic [71:0] pat, input logic [3:0] len);
    logic hit;
    hit = (FILL_BITS'(len) <= fill);
    for (int j = 0; j < WIN_DEPTH; j++) begin
      if ((j < len) && (w[j] != pat[8*j +: 8])) hit = 1'b0;
    end
    return hit;
  endfunction

  // Override hint: first character in bits 7..0 of the text.
  function automatic logic hint_ends(input win_t w, input logic [FILL_BITS-1:0] fill,
                                     input logic [63:0] text,
                                     input logic [HLEN_BITS-1:0] len);
    logic       hit;
    logic [3:0] idx;
    hit = (len != '0) && (FILL_BITS'(len) <= fill);
    for (int k = 0; k < MAX_HINT_BYTES; k++) begin
      idx = 4'(len - HLEN_BITS'(1) - HLEN_BITS'(k));
      if ((k < len) && (w[idx] != text[8*k +: 8])) hit = 1'b0;
    end
    return hit;
  endfunction

endpackage

[design/env_block_crc_validator.sv]
// Top level of the environment block CRC validator: input word register, block
// state, CRC-32 and hint matching, result register. Depends on ecv_pkg.
//
// Takes one byte word per cycle while in_stall is low; results are registered
// from the last byte of a block. The first four bytes of a block form the
// stored checksum; a reflected CRC-32 (poly EDB88320, preset and final XOR
// all ones) runs over the rest, while a nine-byte window looks for a
// configured hint (hint_length 1..8) or, with hint_length 0, the built-in
// names bootcmd=, bootargs=, baudrate=, ethaddr= and stdin=. On the last
// byte one result word reports verdict (1 CRC equals header read little-
// endian, preferred; 2 big-endian; 0 neither), the CRC and hint_found, and
// the block state clears for the next block. Throughput is one byte per
// cycle while the result is not stalled, set by the bytewise CRC update
// between the input register and the block state. A stalled result keeps
// one byte parked in the input register, and in_stall is high while it waits.
// block_size below 5 acts as 5; a smaller block_size written mid-block ends
// the block on the next byte. Write config only while the block is idle.
module env_block_crc_validator
  import ecv_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // byte input channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_data_byte,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           out_verdict,
  output logic [31:0]          out_computed_crc,
  output logic                 out_hint_found,
  // config write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [63:0]          cfg_data
);

  // config registers
  logic [SIZE_BITS-1:0]     block_size_r;
  logic [63:0]              hint_text_r;
  logic [HLEN_BITS-1:0]     hint_length_r;

  // input word register
  logic                     s1_valid_r;
  logic [7:0]               s1_byte_r;

  // per-block state
  logic [31:0]              crc_r, crc_nxt;
  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  logic [31:0]              header_r, header_nxt;
  win_t                     win_r, win_nxt;
  logic [FILL_BITS-1:0]     fill_r, fill_nxt;
  logic                     seen_r, seen_nxt;

  // result register
  logic                     out_valid_r;
  logic [1:0]               verdict_r, verdict_nxt;
  logic [31:0]              res_crc_r, res_crc_nxt;
  logic                     res_hint_r;

  logic                     adv;       // result side can take a new word
  logic                     last;      // byte in s1 closes the block
  logic [SIZE_BITS-1:0]     size_eff;
  logic [HLEN_BITS-1:0]     hlen_eff;
  logic                     hit;
  logic [31:0]              be_hdr;

  assign adv       = !out_valid_r || !out_stall;
  assign in_stall  = s1_valid_r && !adv;
  assign cfg_ready = 1'b1;

  assign size_eff = (block_size_r < SIZE_MIN) ? SIZE_MIN : block_size_r;
  assign hlen_eff = (hint_length_r > HLEN_BITS'(MAX_HINT_BYTES)) ?
                    HLEN_BITS'(MAX_HINT_BYTES) : hint_length_r;

  always_comb begin
    crc_nxt    = crc_r;
    header_nxt = header_r;
    win_nxt    = win_r;
    fill_nxt   = fill_r;
    seen_nxt   = seen_r;
    hit        = 1'b0;
    if (pos_r < POSITION_BITS'(4)) begin
      // header byte, little-endian assembly
      header_nxt[8*pos_r[1:0] +: 8] = s1_byte_r;
    end else begin
      crc_nxt  = crc_byte(crc_r, s1_byte_r);
      win_nxt  = {win_r[WIN_DEPTH-2:0], s1_byte_r};
      fill_nxt = (fill_r < FILL_BITS'(WIN_DEPTH)) ? fill_r + FILL_BITS'(1) : fill_r;
      if (hlen_eff != '0) begin
        hit = hint_ends(win_nxt, fill_nxt, hint_text_r, hlen_eff);
      end else begin
        hit = name_ends(win_nxt, fill_nxt, NAME_BOOTCMD,  4'd8) ||
              name_ends(win_nxt, fill_nxt, NAME_BOOTARGS, 4'd9) ||
              name_ends(win_nxt, fill_nxt, NAME_BAUDRATE, 4'd9) ||
              name_ends(win_nxt, fill_nxt, NAME_ETHADDR,  4'd8) ||
              name_ends(win_nxt, fill_nxt, NAME_STDIN,    4'd6);
      end
      seen_nxt = seen_r | hit;
    end
  end

  assign last    = ({1'b0, pos_r} + (POSITION_BITS+1)'(1)) >=
                   (POSITION_BITS+1)'(size_eff);
  assign pos_nxt = pos_r + POSITION_BITS'(1);

  assign res_crc_nxt = crc_nxt ^ ALL_ONES;
  assign be_hdr      = {header_nxt[7:0], header_nxt[15:8],
                        header_nxt[23:16], header_nxt[31:24]};
  assign verdict_nxt = (res_crc_nxt == header_nxt) ? VERDICT_LE :
                       (res_crc_nxt == be_hdr)     ? VERDICT_BE : VERDICT_NONE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_size_r  <= SIZE_RESET;
      hint_text_r   <= '0;
      hint_length_r <= '0;
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      crc_r         <= ALL_ONES;
      pos_r         <= '0;
      header_r      <= '0;
      win_r         <= '0;
      fill_r        <= '0;
      seen_r        <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_BLOCK_SIZE:  block_size_r  <= cfg_data[SIZE_BITS-1:0];
          REG_HINT_TEXT:   hint_text_r   <= cfg_data;
          REG_HINT_LENGTH: hint_length_r <= cfg_data[HLEN_BITS-1:0];
          default: ;  // unused index, write dropped
        endcase
      end

      // input register loads whenever it drains or is empty
      if (!s1_valid_r || adv) begin
        s1_valid_r <= in_valid;
        s1_byte_r  <= in_data_byte;
      end

      if (adv) begin
        out_valid_r <= s1_valid_r && last;
        if (s1_valid_r) begin
          if (last) begin
            verdict_r  <= verdict_nxt;
            res_crc_r  <= res_crc_nxt;
            res_hint_r <= seen_nxt;
            crc_r      <= ALL_ONES;
            pos_r      <= '0;
            header_r   <= '0;
            win_r      <= '0;
            fill_r     <= '0;
            seen_r     <= 1'b0;
          end else begin
            crc_r      <= crc_nxt;
            pos_r      <= pos_nxt;
            header_r   <= header_nxt;
            win_r      <= win_nxt;
            fill_r     <= fill_nxt;
            seen_r     <= seen_nxt;
          end
        end
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_verdict      = verdict_r;
  assign out_computed_crc = res_crc_r;
  assign out_hint_found   = res_hint_r;

endmodule

[design/ecv_checker.sv]
// Port-level checker for the environment block CRC validator, bound to the top.
// Depends on ecv_pkg and env_block_crc_validator_defines.svh.
`include "env_block_crc_validator_defines.svh"

module ecv_checker
  import ecv_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_verdict,
  input logic [31:0] out_computed_crc,
  input logic        out_hint_found
);

  // only a blocked result can hold back input
  `ECV_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall, "in_stall without stalled result")

  `ECV_ASSERT_NOW(a_verdict_code, out_valid,
    out_verdict == VERDICT_NONE || out_verdict == VERDICT_LE || out_verdict == VERDICT_BE,
    "bad verdict code")

  // a fresh result word comes from a byte word that was accepted into the input
  // register, or one parked there behind a stalled result
  `ECV_ASSERT_NOW(a_result_source, out_valid && !$past(out_valid && out_stall),
    $past(in_valid && !in_stall, 2) || $past(in_stall, 2),
    "result word without accepted byte")

  `ECV_ASSERT_NEXT(a_result_hold, out_valid && out_stall,
    out_valid && $stable(out_verdict) && $stable(out_computed_crc) && $stable(out_hint_found),
    "stalled result word changed")

endmodule

bind env_block_crc_validator ecv_checker u_ecv_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_verdict      (out_verdict),
  .out_computed_crc (out_computed_crc),
  .out_hint_found   (out_hint_found)
);
